// ===== sv/asl_pkg.sv =====
package asl_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int GROUP_SIZE = 4;
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 14;
  localparam int VAL_W      = 10;
  localparam int CODE_W     = 12;
  localparam int REC_W      = 2 * CODE_W;
  localparam int FILL_W     = 6;
  localparam int COUNT_W    = 16;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    KIND_SAMPLE  = 3'd0,
    KIND_DRAIN   = 3'd1,
    KIND_START   = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_OVERCUR = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MODE = 3'd0,
    REG_UP_THRESH  = 3'd1,
    REG_DOWN_THRESH = 3'd2,
    REG_PFX_V      = 3'd3,
    REG_PFX_CLO    = 3'd4,
    REG_PFX_CHI    = 3'd5
  } reg_idx_e;

  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [1:0] RUN_CODE_IDLE = 2'd0;
  localparam logic [1:0] RUN_CODE_LOG  = 2'd1;
  localparam logic [1:0] RUN_CODE_ERR  = 2'd2;

  // Scaled values of one completed group of samples.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] u;
    logic [VAL_W-1:0] i1;
    logic [VAL_W-1:0] i2;
  } grp_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [REC_W-1:0] wdata;
  } ring_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [FILL_W-1:0] fill_nxt;
  } ring_stat_t;

endpackage

// ===== sv/asl_accum.sv =====
module asl_accum
  import asl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sample_en,
  input  logic [SAMPLE_W-1:0] voltage_sample,
  input  logic [SAMPLE_W-1:0] current_high_sample,
  input  logic [SAMPLE_W-1:0] current_low_sample,
  output grp_t                grp
);

  localparam int POS_W = $clog2(GROUP_SIZE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(GROUP_SIZE - 1);

  logic [SUM_W-1:0]    v_sum_r, v_sum_nxt;
  logic [SUM_W-1:0]    ch_sum_r, ch_sum_nxt;
  logic [SUM_W-1:0]    cl_sum_r, cl_sum_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0]    v_add, ch_add, cl_add;
  logic [SAMPLE_W-1:0] v_avg, ch_avg, cl_avg;
  logic                last;

  assign v_add  = v_sum_r + SUM_W'(voltage_sample);
  assign ch_add = ch_sum_r + SUM_W'(current_high_sample);
  assign cl_add = cl_sum_r + SUM_W'(current_low_sample);
  assign last   = (pos_r == POS_LAST);

  // Average of four is a right shift by two.
  assign v_avg  = v_add[SUM_W-1:2];
  assign ch_avg = ch_add[SUM_W-1:2];
  assign cl_avg = cl_add[SUM_W-1:2];

  assign grp.done = last;
  assign grp.u    = v_avg[SAMPLE_W-1:2];
  assign grp.i1   = VAL_W'(ch_avg[SAMPLE_W-1:3]);
  // Low-range gain is approximated by 1/8 + 1/128 + 1/256.
  assign grp.i2   = VAL_W'(cl_avg[SAMPLE_W-1:3]) + VAL_W'(cl_avg[SAMPLE_W-1:7])
                  + VAL_W'(cl_avg[SAMPLE_W-1:8]);

  always_comb begin
    v_sum_nxt  = v_sum_r;
    ch_sum_nxt = ch_sum_r;
    cl_sum_nxt = cl_sum_r;
    pos_nxt    = pos_r;
    if (sample_en) begin
      if (last) begin
        v_sum_nxt  = '0;
        ch_sum_nxt = '0;
        cl_sum_nxt = '0;
        pos_nxt    = '0;
      end else begin
        v_sum_nxt  = v_add;
        ch_sum_nxt = ch_add;
        cl_sum_nxt = cl_add;
        pos_nxt    = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sum_r  <= '0;
      ch_sum_r <= '0;
      cl_sum_r <= '0;
      pos_r    <= '0;
    end else begin
      v_sum_r  <= v_sum_nxt;
      ch_sum_r <= ch_sum_nxt;
      cl_sum_r <= cl_sum_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

// ===== sv/asl_ring.sv =====
module asl_ring
  import asl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ring_cmd_t        cmd,
  output ring_stat_t       stat,
  output logic [REC_W-1:0] rdata
);

  localparam logic [RING_AW-1:0] PTR_LAST = RING_AW'(RING_DEPTH - 1);

  logic [REC_W-1:0]   mem [RING_DEPTH];
  logic [REC_W-1:0]   rdata_r;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [RING_AW-1:0] tail_r, tail_nxt;
  logic [RING_AW-1:0] head_inc, tail_inc;
  logic [RING_AW:0]   diff;
  logic [RING_AW:0]   fill_full;

  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;

  assign stat.full  = (tail_inc == head_r);
  assign stat.empty = (tail_r == head_r);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cmd.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (cmd.push) tail_nxt = tail_inc;
      if (cmd.pop)  head_nxt = head_inc;
    end
  end

  assign diff      = {1'b0, tail_nxt} - {1'b0, head_nxt};
  assign fill_full = (tail_nxt >= head_nxt) ? diff : diff + (RING_AW+1)'(RING_DEPTH);
  assign stat.fill_nxt = FILL_W'(fill_full);

  // A pop never meets a push in the same cycle, and an entry is popped only
  // after the cycle that wrote it, so the registered read needs no bypass.
  always_ff @(posedge clk) begin
    if (cmd.push) mem[tail_r] <= cmd.wdata;
    if (cmd.pop)  rdata_r <= mem[head_r];
  end

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full) else $error("ring push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty) else $error("ring pop while empty");
`endif

endmodule

// ===== sv/autorange_sample_logger.sv =====
// Auto-ranging sample logger.
// Input channel (in_*): one beat per item. in_tuser carries the kind (sample,
// drain, start, stop, overcurrent); in_tdata carries one ADC triplet.
// Output channel (out_*): exactly one result beat per input beat, in order,
// carrying the display or popped codes and the status after that item.
// Configuration (cfg_*): register writes, always ready; write only while idle.
// The result of a beat is registered when the beat is accepted and offered
// in the cycle after. Throughput is one beat per cycle while no result waits;
// every item does its read-modify-write of the record ring and state in the
// accept cycle; a drain reads the ring memory into its registered read port.
// The output register is the only buffer: while out_tready is low and a result
// waits, in_tready is low; a result taken in the same cycle frees the slot.
// Synchronous reset (rst_n low) empties the ring, clears the sample group
// and the record count, selects high range, enters idle and loads the default
// thresholds (up 500, down 5) and prefixes (voltage 0, low 1, high 2).
// Ring entries are undefined until written; there is no clearing pass.
module autorange_sample_logger
  import asl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] voltage_sample, [23:12] current_high_sample,
  // [35:24] current_low_sample, [39:36] zero
  input  logic [39:0]           in_tdata,
  // [2:0] kind
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] voltage_code, [23:12] current_code, [24] code_valid, [25] shunt_low,
  // [27:26] run_state, [33:28] fill_level, [49:34] record_count, [55:50] zero
  output logic [55:0]           out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOG  = 3'b010,
    ST_ERR  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               low_r, low_nxt;
  logic [VAL_W-1:0]   up_r, up_nxt;
  logic [VAL_W-1:0]   down_r, down_nxt;
  logic [1:0]         pfx_v_r, pfx_v_nxt;
  logic [1:0]         pfx_lo_r, pfx_lo_nxt;
  logic [1:0]         pfx_hi_r, pfx_hi_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               code_valid_r, code_valid_nxt;
  logic               from_mem_r, from_mem_nxt;
  logic [CODE_W-1:0]  vcode_r, vcode_nxt;
  logic [CODE_W-1:0]  ccode_r, ccode_nxt;
  logic               shunt_r;
  logic [1:0]         run_code_r;
  logic [FILL_W-1:0]  fill_r;

  logic               accept;
  kind_e              kind;
  grp_t               grp;
  ring_cmd_t          rcmd;
  ring_stat_t         rstat;
  logic [REC_W-1:0]   rdata;
  logic               hyst_low, grp_low;
  logic [CODE_W-1:0]  grp_vcode, grp_ccode;
  logic [1:0]         cfg_mode;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign kind      = kind_e'(in_tuser);
  assign cfg_ready = 1'b1;

  asl_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .sample_en           (accept && (kind == KIND_SAMPLE)),
    .voltage_sample      (in_tdata[11:0]),
    .current_high_sample (in_tdata[23:12]),
    .current_low_sample  (in_tdata[35:24]),
    .grp                 (grp)
  );

  asl_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rcmd),
    .stat  (rstat),
    .rdata (rdata)
  );

  // Hysteresis: leave low range at or above the up threshold, enter it at or
  // below the down threshold.
  assign hyst_low  = low_r ? !(grp.i2 >= up_r) : (grp.i1 <= down_r);
  assign grp_low   = ((state_r == ST_IDLE) || (mode_r == MODE_AUTO)) ? hyst_low : low_r;
  assign grp_vcode = {pfx_v_r, grp.u};
  assign grp_ccode = grp_low ? {pfx_lo_r, grp.i2} : {pfx_hi_r, grp.i1};
  assign cfg_mode  = (cfg_data[1:0] == MODE_BAD) ? MODE_AUTO : cfg_data[1:0];

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    low_nxt        = low_r;
    up_nxt         = up_r;
    down_nxt       = down_r;
    pfx_v_nxt      = pfx_v_r;
    pfx_lo_nxt     = pfx_lo_r;
    pfx_hi_nxt     = pfx_hi_r;
    count_nxt      = count_r;
    code_valid_nxt = 1'b0;
    from_mem_nxt   = 1'b0;
    vcode_nxt      = '0;
    ccode_nxt      = '0;
    rcmd.push      = 1'b0;
    rcmd.pop       = 1'b0;
    rcmd.clear     = 1'b0;
    rcmd.wdata     = {grp_vcode, grp_ccode};

    if (accept) begin
      case (kind)
        KIND_SAMPLE: begin
          if (grp.done) begin
            case (state_r)
              ST_IDLE: begin
                low_nxt        = grp_low;
                code_valid_nxt = 1'b1;
                vcode_nxt      = grp_vcode;
                ccode_nxt      = grp_ccode;
              end
              ST_LOG: begin
                if (rstat.full) begin
                  state_nxt = ST_ERR;
                end else begin
                  low_nxt   = grp_low;
                  rcmd.push = 1'b1;
                  count_nxt = count_r + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        KIND_DRAIN: begin
          if ((state_r == ST_LOG) && !rstat.empty) begin
            rcmd.pop       = 1'b1;
            code_valid_nxt = 1'b1;
            from_mem_nxt   = 1'b1;
          end
        end
        KIND_START: begin
          if (state_r != ST_LOG) begin
            rcmd.clear = 1'b1;
            count_nxt  = '0;
            state_nxt  = ST_LOG;
          end
        end
        KIND_STOP: begin
          state_nxt = ST_IDLE;
          mode_nxt  = MODE_AUTO;
          low_nxt   = 1'b0;
        end
        KIND_OVERCUR: state_nxt = ST_ERR;
        default: ;
      endcase
    end

    if (cfg_valid) begin
      case (cfg_index)
        REG_RANGE_MODE: begin
          mode_nxt = cfg_mode;
          low_nxt  = (cfg_mode == MODE_LOW);
        end
        REG_UP_THRESH:   up_nxt     = cfg_data;
        REG_DOWN_THRESH: down_nxt   = cfg_data;
        REG_PFX_V:       pfx_v_nxt  = cfg_data[1:0];
        REG_PFX_CLO:     pfx_lo_nxt = cfg_data[1:0];
        REG_PFX_CHI:     pfx_hi_nxt = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [1:0] run_code(state_t s);
    case (s)
      ST_LOG:  return RUN_CODE_LOG;
      ST_ERR:  return RUN_CODE_ERR;
      default: return RUN_CODE_IDLE;
    endcase
  endfunction

  assign out_valid_nxt = accept ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_AUTO;
      low_r       <= 1'b0;
      up_r        <= VAL_W'(500);
      down_r      <= VAL_W'(5);
      pfx_v_r     <= 2'd0;
      pfx_lo_r    <= 2'd1;
      pfx_hi_r    <= 2'd2;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      low_r       <= low_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      pfx_v_r     <= pfx_v_nxt;
      pfx_lo_r    <= pfx_lo_nxt;
      pfx_hi_r    <= pfx_hi_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      code_valid_r <= code_valid_nxt;
      from_mem_r   <= from_mem_nxt;
      vcode_r      <= vcode_nxt;
      ccode_r      <= ccode_nxt;
      shunt_r      <= low_nxt;
      run_code_r   <= run_code(state_nxt);
      fill_r       <= rstat.fill_nxt;
    end
  end

  // A record holds the voltage code in its upper half and the current code
  // in its lower half.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, count_r, fill_r, run_code_r, shunt_r, code_valid_r,
                       from_mem_r ? rdata[CODE_W-1:0]     : ccode_r,
                       from_mem_r ? rdata[REC_W-1:CODE_W] : vcode_r};

  // The count field follows the live counter: it only changes on accept,
  // which cannot happen while a result is held.
`ifndef SYNTHESIS
  a_pop_only_logging: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && from_mem_r) |-> (state_r == ST_LOG))
    else $error("record popped outside logging");
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (kind == KIND_START) && (state_r != ST_LOG))
      |=> (count_r == '0) && (fill_r == '0))
    else $error("start did not clear ring and count");
  a_count_moves_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_nxt != count_r) |-> (rcmd.push || rcmd.clear))
    else $error("record count changed without a store or start");
  a_error_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (state_r == ST_ERR)) |=> !code_valid_r)
    else $error("valid codes produced in error state");
`endif

endmodule
